// File: sv/four_square_digraph_cipher_core_defines.svh
// Assertion macros for the four-square digraph cipher core.
// Taken in by the checker; depends on nothing else.

`ifndef FOUR_SQUARE_DIGRAPH_CIPHER_CORE_DEFINES_SVH
`define FOUR_SQUARE_DIGRAPH_CIPHER_CORE_DEFINES_SVH

// check next cycle, muted while in reset
`define FSDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// check next cycle, live during reset
`define FSDC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/fsdc_pkg.sv
// Shared types, constants and helper functions for the four-square cipher core.
// Used by every module of the block; depends on nothing.

package fsdc_pkg;

    localparam int LETTER_W     = 6;
    localparam int SIDE_W       = 4;
    localparam int CELLS_W      = 7;
    localparam int GRID_W       = 3;
    localparam int PROD_W       = LETTER_W + SIDE_W + 1;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 3;
    localparam int DEF_MAX_SIDE = 6;
    localparam int MIN_SIDE     = 2;
    localparam int QUEUE_DEPTH  = 4;
    localparam int OUTQ_DEPTH   = 4;

    localparam logic [GRID_W-1:0]    GRID_SIDE_RST    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_SIDE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DECRYPT_MODE = 1'b1;

    typedef enum logic [1:0] {
        ACT_LOAD_UR = 2'd0,
        ACT_LOAD_LL = 2'd1,
        ACT_LETTER  = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        OP_LOAD_UR   = 3'd0,
        OP_LOAD_LL   = 3'd1,
        OP_SINGLE    = 3'd2,
        OP_PASS_PAIR = 3'd3,
        OP_ENC_PAIR  = 3'd4,
        OP_DEC_PAIR  = 3'd5
    } t_op_kind;

    typedef struct packed {
        t_op_kind              kind;
        logic [LETTER_W-1:0]   a;
        logic [LETTER_W-1:0]   b;
        logic                  oor;
    } t_op;

    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic                last;
        logic                oor;
    } t_res;

    typedef struct packed {
        logic [SIDE_W-1:0]  side;
        logic [CELLS_W-1:0] cells;
        logic               decrypt;
    } t_cfg;

    // largest multiple of side not above v, i.e. (v / side) * side
    function automatic logic [LETTER_W-1:0] f_row_base(
        input logic [LETTER_W-1:0] v,
        input logic [SIDE_W-1:0]   side
    );
        logic [LETTER_W-1:0] base;
        logic [PROD_W-1:0]   m_lo;
        logic [PROD_W-1:0]   m_hi;
        logic [PROD_W-1:0]   v_w;
        base = '0;
        v_w  = PROD_W'(v);
        for (int k = 1; k < (1 << LETTER_W); k++) begin
            m_lo = PROD_W'(k) * PROD_W'(side);
            m_hi = m_lo + PROD_W'(side);
            if ((m_lo <= v_w) && (m_hi > v_w)) begin
                base = base | m_lo[LETTER_W-1:0];
            end
        end
        return base;
    endfunction

endpackage

// File: sv/fsdc_front.sv
// Front end: accepts items, pairs letters, sorts them into operations and queues them.
// Depends on fsdc_pkg.

module fsdc_front #(
    parameter int MAX_SIDE = fsdc_pkg::DEF_MAX_SIDE
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fsdc_pkg::t_cfg                i_cfg,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic [1:0]                    i_action,
    input  logic [fsdc_pkg::LETTER_W-1:0] i_cell_index,
    input  logic [fsdc_pkg::LETTER_W-1:0] i_letter,
    input  logic                          i_message_end,
    output fsdc_pkg::t_op                 o_op,
    output logic                          o_op_valid,
    input  logic                          i_op_pop
);

    localparam int CELLS = MAX_SIDE * MAX_SIDE;
    localparam int QAW   = $clog2(fsdc_pkg::QUEUE_DEPTH);
    localparam int QCW   = $clog2(fsdc_pkg::QUEUE_DEPTH + 1);

    logic [fsdc_pkg::LETTER_W-1:0] r_held;
    logic                          r_holding;
    logic [fsdc_pkg::LETTER_W-1:0] n_held;
    logic                          n_holding;

    fsdc_pkg::t_op                 r_q [fsdc_pkg::QUEUE_DEPTH];
    logic [QAW-1:0]                r_wr_ptr;
    logic [QAW-1:0]                r_rd_ptr;
    logic [QCW-1:0]                r_count;

    fsdc_pkg::t_op                 op;
    logic                          push_op;
    logic                          accept;
    logic                          wr;
    logic                          load_ok;
    logic                          held_oor;
    logic                          in_oor;
    logic [fsdc_pkg::LETTER_W-1:0] held_base;
    logic [fsdc_pkg::LETTER_W-1:0] in_base;

    assign accept    = i_push && !o_full;
    assign wr        = accept && push_op;
    assign held_base = fsdc_pkg::f_row_base(r_held, i_cfg.side);
    assign in_base   = fsdc_pkg::f_row_base(i_letter, i_cfg.side);
    assign held_oor  = fsdc_pkg::CELLS_W'(r_held) >= i_cfg.cells;
    assign in_oor    = fsdc_pkg::CELLS_W'(i_letter) >= i_cfg.cells;
    assign load_ok   = (fsdc_pkg::CELLS_W'(i_cell_index) < fsdc_pkg::CELLS_W'(CELLS))
                    && (fsdc_pkg::CELLS_W'(i_letter) < fsdc_pkg::CELLS_W'(CELLS));

    always_comb begin
        op.kind   = fsdc_pkg::OP_SINGLE;
        op.a      = i_letter;
        op.b      = i_letter;
        op.oor    = in_oor;
        push_op   = 1'b0;
        n_held    = r_held;
        n_holding = r_holding;
        case (fsdc_pkg::t_action'(i_action))
            fsdc_pkg::ACT_LOAD_UR: begin
                op.kind = fsdc_pkg::OP_LOAD_UR;
                op.a    = i_cell_index;
                push_op = load_ok;
            end
            fsdc_pkg::ACT_LOAD_LL: begin
                op.kind = fsdc_pkg::OP_LOAD_LL;
                op.a    = i_cell_index;
                push_op = load_ok;
            end
            fsdc_pkg::ACT_LETTER: begin
                if (!r_holding) begin
                    if (i_message_end) begin
                        push_op = 1'b1;
                    end else begin
                        n_held    = i_letter;
                        n_holding = 1'b1;
                    end
                end else begin
                    n_holding = 1'b0;
                    push_op   = 1'b1;
                    op.a      = r_held;
                    if (held_oor || in_oor) begin
                        op.kind = fsdc_pkg::OP_PASS_PAIR;
                        op.oor  = 1'b1;
                    end else if (i_cfg.decrypt) begin
                        op.kind = fsdc_pkg::OP_DEC_PAIR;
                        op.oor  = 1'b0;
                    end else begin
                        op.kind = fsdc_pkg::OP_ENC_PAIR;
                        op.a    = held_base + i_letter - in_base;
                        op.b    = in_base + r_held - held_base;
                        op.oor  = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held    <= '0;
            r_holding <= 1'b0;
        end else if (accept) begin
            r_held    <= n_held;
            r_holding <= n_holding;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr) begin
                r_wr_ptr <= r_wr_ptr + QAW'(1);
            end
            if (i_op_pop) begin
                r_rd_ptr <= r_rd_ptr + QAW'(1);
            end
            r_count <= r_count + QCW'(wr) - QCW'(i_op_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wr_ptr] <= op;
        end
    end

    assign o_op       = r_q[r_rd_ptr];
    assign o_op_valid = r_count != '0;
    assign o_full     = r_count == QCW'(fsdc_pkg::QUEUE_DEPTH);

endmodule

// File: sv/fsdc_back.sv
// Back end: square and position memories, load writes, pair lookups and result forming.
// Depends on fsdc_pkg.

module fsdc_back #(
    parameter int MAX_SIDE = fsdc_pkg::DEF_MAX_SIDE
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [fsdc_pkg::SIDE_W-1:0] i_side,
    input  fsdc_pkg::t_op               i_op,
    input  logic                        i_op_valid,
    output logic                        o_op_pop,
    input  logic                        i_room,
    output fsdc_pkg::t_res              o_res0,
    output fsdc_pkg::t_res              o_res1,
    output logic                        o_push,
    output logic                        o_two
);

    localparam int CELLS = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(CELLS);

    logic [fsdc_pkg::LETTER_W-1:0] r_ur_sq  [CELLS];
    logic [fsdc_pkg::LETTER_W-1:0] r_ll_sq  [CELLS];
    logic [fsdc_pkg::LETTER_W-1:0] r_ur_pos [CELLS];
    logic [fsdc_pkg::LETTER_W-1:0] r_ll_pos [CELLS];

    logic [fsdc_pkg::LETTER_W-1:0] r_ur_sq_q;
    logic [fsdc_pkg::LETTER_W-1:0] r_ll_sq_q;
    logic [fsdc_pkg::LETTER_W-1:0] r_ur_pos_q;
    logic [fsdc_pkg::LETTER_W-1:0] r_ll_pos_q;

    logic                          r_s2_valid;
    logic                          n_s2_valid;
    fsdc_pkg::t_op                 r_s2_op;

    logic                          pop;
    logic                          s2_fire;
    logic                          makes_result;
    logic [AW-1:0]                 addr_a;
    logic [AW-1:0]                 addr_b;
    logic [fsdc_pkg::LETTER_W-1:0] base_u;
    logic [fsdc_pkg::LETTER_W-1:0] base_l;

    assign s2_fire  = r_s2_valid && i_room;
    assign pop      = i_op_valid && (!r_s2_valid || s2_fire);
    assign o_op_pop = pop;
    assign addr_a   = i_op.a[AW-1:0];
    assign addr_b   = i_op.b[AW-1:0];

    assign makes_result = (i_op.kind == fsdc_pkg::OP_SINGLE)
                       || (i_op.kind == fsdc_pkg::OP_PASS_PAIR)
                       || (i_op.kind == fsdc_pkg::OP_ENC_PAIR)
                       || (i_op.kind == fsdc_pkg::OP_DEC_PAIR);

    always_ff @(posedge i_clk) begin
        if (pop && (i_op.kind == fsdc_pkg::OP_LOAD_UR)) begin
            r_ur_sq[addr_a] <= i_op.b;
        end
        if (pop) begin
            r_ur_sq_q <= r_ur_sq[addr_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && (i_op.kind == fsdc_pkg::OP_LOAD_UR)) begin
            r_ur_pos[addr_b] <= i_op.a;
        end
        if (pop) begin
            r_ur_pos_q <= r_ur_pos[addr_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && (i_op.kind == fsdc_pkg::OP_LOAD_LL)) begin
            r_ll_sq[addr_a] <= i_op.b;
        end
        if (pop) begin
            r_ll_sq_q <= r_ll_sq[addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && (i_op.kind == fsdc_pkg::OP_LOAD_LL)) begin
            r_ll_pos[addr_b] <= i_op.a;
        end
        if (pop) begin
            r_ll_pos_q <= r_ll_pos[addr_b];
        end
    end

    always_comb begin
        n_s2_valid = r_s2_valid;
        if (pop) begin
            n_s2_valid = makes_result;
        end else if (s2_fire) begin
            n_s2_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= n_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_s2_op <= i_op;
        end
    end

    assign base_u = fsdc_pkg::f_row_base(r_ur_pos_q, i_side);
    assign base_l = fsdc_pkg::f_row_base(r_ll_pos_q, i_side);

    always_comb begin
        o_res0.letter = r_s2_op.a;
        o_res0.last   = 1'b0;
        o_res0.oor    = r_s2_op.oor;
        o_res1.letter = r_s2_op.b;
        o_res1.last   = 1'b1;
        o_res1.oor    = r_s2_op.oor;
        o_two         = 1'b1;
        case (r_s2_op.kind)
            fsdc_pkg::OP_SINGLE: begin
                o_res0.last = 1'b1;
                o_two       = 1'b0;
            end
            fsdc_pkg::OP_PASS_PAIR: begin
            end
            fsdc_pkg::OP_ENC_PAIR: begin
                o_res0.letter = r_ur_sq_q;
                o_res1.letter = r_ll_sq_q;
            end
            fsdc_pkg::OP_DEC_PAIR: begin
                o_res0.letter = base_u + r_ll_pos_q - base_l;
                o_res1.letter = base_l + r_ur_pos_q - base_u;
            end
            default: begin
                o_two = 1'b0;
            end
        endcase
    end

    assign o_push = s2_fire;

endmodule

// File: sv/fsdc_outq.sv
// Result queue: takes one or two results a cycle, hands out one a cycle.
// Depends on fsdc_pkg.

module fsdc_outq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  fsdc_pkg::t_res i_res0,
    input  fsdc_pkg::t_res i_res1,
    input  logic           i_push,
    input  logic           i_two,
    output logic           o_room,
    output fsdc_pkg::t_res o_res,
    output logic           o_empty,
    input  logic           i_pop
);

    localparam int OAW = $clog2(fsdc_pkg::OUTQ_DEPTH);
    localparam int OCW = $clog2(fsdc_pkg::OUTQ_DEPTH + 1);

    fsdc_pkg::t_res r_q [fsdc_pkg::OUTQ_DEPTH];
    logic [OAW-1:0] r_wr_ptr;
    logic [OAW-1:0] r_rd_ptr;
    logic [OCW-1:0] r_count;

    logic           pop;
    logic [OCW-1:0] n_in;

    assign pop  = i_pop && !o_empty;
    assign n_in = !i_push ? OCW'(0) : (i_two ? OCW'(2) : OCW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + n_in[OAW-1:0];
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + OAW'(1);
            end
            r_count <= r_count + n_in - OCW'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr] <= i_res0;
            if (i_two) begin
                r_q[r_wr_ptr + OAW'(1)] <= i_res1;
            end
        end
    end

    assign o_res   = r_q[r_rd_ptr];
    assign o_empty = r_count == '0;
    assign o_room  = r_count <= OCW'(fsdc_pkg::OUTQ_DEPTH - 2);

endmodule

// File: sv/four_square_digraph_cipher_core.sv
// Top level of the four-square digraph cipher core: config registers, front, back, result queue.
// Depends on fsdc_pkg, fsdc_front, fsdc_back and fsdc_outq.
//
//  Channel   Ports                                          Transfer
//  -------   ---------------------------------------------  ---------------------------
//  input     i_action i_cell_index i_letter i_message_end   push && !full
//  result    o_out_letter o_run_last o_out_of_range         pop && !empty
//  config    i_cfg_index i_cfg_data                         i_cfg_valid && o_cfg_ready
//
// One item enters per cycle while full is low; a pair's two results pass the operation queue,
// the back end's registered lookup stage and the result queue, and leave one per cycle.
// If not stalled, the back end retires one queued operation per cycle via registered-read memories.
// Synchronous reset clears control state only; the squares hold garbage until loaded.
// full rises when the operation queue holds four entries; the back end stalls while the
// result queue has fewer than two free slots.

module four_square_digraph_cipher_core #(
    parameter int MAX_SIDE = fsdc_pkg::DEF_MAX_SIDE
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [1:0]                      i_action,
    input  logic [fsdc_pkg::LETTER_W-1:0]   i_cell_index,
    input  logic [fsdc_pkg::LETTER_W-1:0]   i_letter,
    input  logic                            i_message_end,
    output logic                            empty,
    input  logic                            pop,
    output logic [fsdc_pkg::LETTER_W-1:0]   o_out_letter,
    output logic                            o_run_last,
    output logic                            o_out_of_range,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [fsdc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fsdc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic [fsdc_pkg::GRID_W-1:0] r_grid_side;
    logic                        r_decrypt_mode;

    fsdc_pkg::t_cfg              cfg;
    fsdc_pkg::t_op               op;
    logic                        op_valid;
    logic                        op_pop;
    fsdc_pkg::t_res              res0;
    fsdc_pkg::t_res              res1;
    fsdc_pkg::t_res              head;
    logic                        res_push;
    logic                        res_two;
    logic                        room;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_side    <= fsdc_pkg::GRID_SIDE_RST;
            r_decrypt_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                fsdc_pkg::REG_GRID_SIDE:    r_grid_side    <= i_cfg_data[fsdc_pkg::GRID_W-1:0];
                fsdc_pkg::REG_DECRYPT_MODE: r_decrypt_mode <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (fsdc_pkg::SIDE_W'(r_grid_side) < fsdc_pkg::SIDE_W'(fsdc_pkg::MIN_SIDE)) begin
            cfg.side = fsdc_pkg::SIDE_W'(fsdc_pkg::MIN_SIDE);
        end else if (fsdc_pkg::SIDE_W'(r_grid_side) > fsdc_pkg::SIDE_W'(MAX_SIDE)) begin
            cfg.side = fsdc_pkg::SIDE_W'(MAX_SIDE);
        end else begin
            cfg.side = fsdc_pkg::SIDE_W'(r_grid_side);
        end
        cfg.cells   = fsdc_pkg::CELLS_W'(cfg.side) * fsdc_pkg::CELLS_W'(cfg.side);
        cfg.decrypt = r_decrypt_mode;
    end

    fsdc_front #(
        .MAX_SIDE (MAX_SIDE)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_push        (push),
        .o_full        (full),
        .i_action      (i_action),
        .i_cell_index  (i_cell_index),
        .i_letter      (i_letter),
        .i_message_end (i_message_end),
        .o_op          (op),
        .o_op_valid    (op_valid),
        .i_op_pop      (op_pop)
    );

    fsdc_back #(
        .MAX_SIDE (MAX_SIDE)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_side     (cfg.side),
        .i_op       (op),
        .i_op_valid (op_valid),
        .o_op_pop   (op_pop),
        .i_room     (room),
        .o_res0     (res0),
        .o_res1     (res1),
        .o_push     (res_push),
        .o_two      (res_two)
    );

    fsdc_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res0  (res0),
        .i_res1  (res1),
        .i_push  (res_push),
        .i_two   (res_two),
        .o_room  (room),
        .o_res   (head),
        .o_empty (empty),
        .i_pop   (pop)
    );

    assign o_out_letter   = head.letter;
    assign o_run_last     = head.last;
    assign o_out_of_range = head.oor;

endmodule

// File: sv/fsdc_checker.sv
// Port-level checks for the four-square digraph cipher core, bound to the top level.
// Depends on fsdc_pkg and four_square_digraph_cipher_core_defines.svh.

`include "four_square_digraph_cipher_core_defines.svh"

module fsdc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          empty,
    input logic                          pop,
    input logic [fsdc_pkg::LETTER_W-1:0] o_out_letter,
    input logic                          o_run_last,
    input logic                          o_out_of_range
);

    `FSDC_ASSERT_NEXT_ALWAYS(a_reset_drains, i_clk, !i_rst_n, empty ##1 empty, "results after reset")

    `FSDC_ASSERT_NEXT(a_pair_completes, i_clk, i_rst_n, pop && !empty && !o_run_last, !empty && o_run_last, "pair second result missing")

    `FSDC_ASSERT_NEXT(a_pair_flag_match, i_clk, i_rst_n, pop && !empty && !o_run_last, o_out_of_range == $past(o_out_of_range), "pair range flags differ")

    `FSDC_ASSERT_NEXT(a_head_holds, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_out_letter), "waiting result dropped")

endmodule

bind four_square_digraph_cipher_core fsdc_checker u_fsdc_checker (.*);
